### sv/prefix_code_bit_packer_top_macros.svh
// assertion macros used by the packer module
`ifndef PREFIX_CODE_BIT_PACKER_TOP_MACROS_SVH
`define PREFIX_CODE_BIT_PACKER_TOP_MACROS_SVH

// checked on aclk, idle while aresetn is low
`define PCBP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// checked on aclk in and out of reset
`define PCBP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### sv/pcbp_pkg.sv
`timescale 1ns / 1ps

package pcbp_pkg;

    localparam int BYTE_BITS = 8;
    localparam int CODE_W    = 32;
    localparam int LEN_W     = 6;
    localparam int SYM_W     = 8;
    localparam int ACC_W     = CODE_W + BYTE_BITS - 1;
    localparam int CNT_W     = 6;
    localparam int VB_W      = 4;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } opcode_t;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
    } table_entry_t;

    typedef struct packed {
        logic         is_flush;
        table_entry_t entry;
    } work_t;

endpackage

### sv/pcbp_table.sv
`timescale 1ns / 1ps

module pcbp_table
    import pcbp_pkg::*;
#(
    parameter int SYMBOL_COUNT    = 256,
    parameter int MAX_CODE_LENGTH = 32
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        opcode,
    input  logic [SYM_W-1:0]  symbol,
    input  logic [CODE_W-1:0] code_bits,
    input  logic [LEN_W-1:0]  code_length,
    output logic              work_valid,
    output work_t             work,
    input  logic              work_take
);

    localparam int AW        = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int LEN_LIMIT = (MAX_CODE_LENGTH < CODE_W) ? MAX_CODE_LENGTH : CODE_W;

    table_entry_t mem [SYMBOL_COUNT];

    logic              work_valid_reg;
    logic              work_valid_next;
    work_t             work_reg;
    logic              accept;
    logic              in_range;
    logic [AW+SYM_W-1:0] sym_ext;
    logic [AW-1:0]     addr;
    logic [LEN_W-1:0]  len_clamped;
    logic              is_load;
    logic              is_encode;
    logic              is_flush;

    assign in_ready  = !work_valid_reg || work_take;
    assign accept    = in_valid && in_ready;
    assign sym_ext   = {{AW{1'b0}}, symbol};
    assign addr      = sym_ext[AW-1:0];
    assign in_range  = int'(symbol) < SYMBOL_COUNT;
    assign is_load   = opcode == OP_LOAD;
    assign is_encode = opcode == OP_ENCODE;
    assign is_flush  = opcode == OP_FLUSH;

    assign len_clamped = (code_length > LEN_W'(LEN_LIMIT)) ? LEN_W'(LEN_LIMIT) : code_length;

    always_comb begin
        work_valid_next = work_valid_reg;
        if (accept) begin
            work_valid_next = (is_encode && in_range) || is_flush;
        end else if (work_take) begin
            work_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
        end else begin
            work_valid_reg <= work_valid_next;
        end
    end

    // table write on load, registered read on encode
    always_ff @(posedge aclk) begin
        if (accept && is_load && in_range) begin
            mem[addr] <= '{code: code_bits, len: len_clamped};
        end
        if (accept) begin
            work_reg.is_flush <= is_flush;
            work_reg.entry    <= mem[addr];
        end
    end

    assign work_valid = work_valid_reg;
    assign work       = work_reg;

endmodule

### sv/pcbp_packer.sv
`timescale 1ns / 1ps

module pcbp_packer
    import pcbp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                work_valid,
    input  work_t               work,
    output logic                work_take,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [BYTE_BITS-1:0] m_out_byte,
    output logic [VB_W-1:0]     m_valid_bits,
    output logic                m_last
);

    `include "prefix_code_bit_packer_top_macros.svh"

    logic [ACC_W-1:0]     acc_reg;
    logic [ACC_W-1:0]     acc_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 m_valid_reg;
    logic [BYTE_BITS-1:0] byte_reg;
    logic [BYTE_BITS-1:0] byte_next;
    logic [VB_W-1:0]      vb_reg;
    logic [VB_W-1:0]      vb_next;
    logic                 last_reg;
    logic                 last_next;
    logic                 emit;
    logic                 out_free;
    logic [CNT_W-1:0]     total;
    logic [ACC_W-1:0]     mask;
    logic [ACC_W-1:0]     merged;
    logic [BYTE_BITS-1:0] drain_byte;
    logic [BYTE_BITS-1:0] merge_byte;
    logic [BYTE_BITS-1:0] flush_byte;
    logic [VB_W-1:0]      flush_shift;

    assign out_free    = !m_valid_reg || m_ready;
    assign total       = {3'b000, cnt_reg[2:0]} + work.entry.len;
    assign mask        = (ACC_W'(1) << work.entry.len) - ACC_W'(1);
    assign merged      = (acc_reg << work.entry.len) | (ACC_W'(work.entry.code) & mask);
    assign drain_byte  = BYTE_BITS'(acc_reg >> (cnt_reg - CNT_W'(BYTE_BITS)));
    assign merge_byte  = BYTE_BITS'(merged >> (total - CNT_W'(BYTE_BITS)));
    assign flush_shift = VB_W'(BYTE_BITS) - {1'b0, cnt_reg[2:0]};
    assign flush_byte  = BYTE_BITS'(acc_reg << flush_shift);

    always_comb begin
        work_take = 1'b0;
        emit      = 1'b0;
        byte_next = drain_byte;
        vb_next   = VB_W'(BYTE_BITS);
        last_next = 1'b0;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        if (cnt_reg >= CNT_W'(BYTE_BITS)) begin
            // whole bytes still buffered
            if (out_free) begin
                emit      = 1'b1;
                last_next = cnt_reg < CNT_W'(2 * BYTE_BITS);
                cnt_next  = cnt_reg - CNT_W'(BYTE_BITS);
            end
        end else if (work_valid) begin
            if (work.is_flush) begin
                if (cnt_reg == '0) begin
                    work_take = 1'b1;
                end else if (out_free) begin
                    work_take = 1'b1;
                    emit      = 1'b1;
                    byte_next = flush_byte;
                    vb_next   = {1'b0, cnt_reg[2:0]};
                    last_next = 1'b1;
                    cnt_next  = '0;
                end
            end else if (total < CNT_W'(BYTE_BITS)) begin
                work_take = 1'b1;
                acc_next  = merged;
                cnt_next  = total;
            end else if (out_free) begin
                work_take = 1'b1;
                emit      = 1'b1;
                byte_next = merge_byte;
                last_next = total < CNT_W'(2 * BYTE_BITS);
                acc_next  = merged;
                cnt_next  = total - CNT_W'(BYTE_BITS);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (emit) begin
            byte_reg <= byte_next;
            vb_reg   <= vb_next;
            last_reg <= last_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = byte_reg;
    assign m_valid_bits = vb_reg;
    assign m_last       = last_reg;

    `PCBP_ASSERT(a_vb_range,
        m_valid_reg |-> (vb_reg != '0 && vb_reg <= VB_W'(BYTE_BITS)),
        "valid_bits out of range")
    `PCBP_ASSERT(a_partial_is_last,
        (m_valid_reg && vb_reg < VB_W'(BYTE_BITS)) |-> last_reg,
        "partial word not marked last")
    `PCBP_ASSERT(a_take_when_low,
        work_take |-> (cnt_reg < CNT_W'(BYTE_BITS)),
        "work taken with whole byte buffered")
    `PCBP_ASSERT(a_no_emit_on_stall,
        (m_valid_reg && !m_ready) |=> ($stable(byte_reg) && $stable(last_reg)),
        "word changed while stalled")
    `PCBP_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(ACC_W), "bit count overflow")
    `PCBP_ASSERT_ALWAYS(a_reset_clears,
        !aresetn |=> (cnt_reg == '0 && !m_valid_reg),
        "state not cleared by reset")

endmodule

### sv/prefix_code_bit_packer_top.sv
`timescale 1ns / 1ps
// path: an encode or flush word passes the work register, then the output word register
// throughput: one item per cycle while m_ready is high and each item completes at most
// one word; more words per item stall the input behind the single output word register
// reset: synchronous active-low aresetn clears the bit buffer and the handshakes; the code
// table is not cleared and holds undefined entries until loaded

module prefix_code_bit_packer_top
    import pcbp_pkg::*;
#(
    parameter int SYMBOL_COUNT    = 256,
    parameter int MAX_CODE_LENGTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_opcode,
    input  logic [SYM_W-1:0]     s_symbol,
    input  logic [CODE_W-1:0]    s_code_bits,
    input  logic [LEN_W-1:0]     s_code_length,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [BYTE_BITS-1:0] m_out_byte,
    output logic [VB_W-1:0]      m_valid_bits,
    output logic                 m_last
);

    logic  work_valid;
    work_t work;
    logic  work_take;

    pcbp_table #(
        .SYMBOL_COUNT    (SYMBOL_COUNT),
        .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
    ) u_table (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .opcode      (s_opcode),
        .symbol      (s_symbol),
        .code_bits   (s_code_bits),
        .code_length (s_code_length),
        .work_valid  (work_valid),
        .work        (work),
        .work_take   (work_take)
    );

    pcbp_packer u_packer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .work_valid   (work_valid),
        .work         (work),
        .work_take    (work_take),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_valid_bits (m_valid_bits),
        .m_last       (m_last)
    );

endmodule

### tb/prefix_code_bit_packer_checker.sv
`timescale 1ns / 1ps

module prefix_code_bit_packer_checker
    import pcbp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [1:0]           s_opcode,
    input  logic [SYM_W-1:0]     s_symbol,
    input  logic [CODE_W-1:0]    s_code_bits,
    input  logic [LEN_W-1:0]     s_code_length,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic [BYTE_BITS-1:0] m_out_byte,
    input  logic [VB_W-1:0]      m_valid_bits,
    input  logic                 m_last,
    output int                   fail_count,
    output int                   words_waiting,
    output int                   words_in,
    output int                   words_out
);

    typedef struct packed {
        logic [BYTE_BITS-1:0] out_byte;
        logic [VB_W-1:0]      valid_bits;
        logic                 last;
    } packed_byte_t;

    table_entry_t   code_table [2**SYM_W];
    logic [6:0]     held_bits;
    logic [2:0]     held_count;
    packed_byte_t   byte_queue [$];

    // load an entry, or add to the bit stream model and queue the bytes it completes
    task automatic pack_word(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
        logic [63:0]  acc;
        int           code_len;
        int           total;
        packed_byte_t w;
        case (op)
            OP_LOAD: begin
                code_table[sym].code = bits;
                code_table[sym].len  = (len > CODE_W) ? LEN_W'(CODE_W) : len;
            end
            OP_ENCODE: begin
                code_len = int'(code_table[sym].len);
                if (code_len != 0) begin
                    acc = (64'(held_bits) << code_len) |
                          (64'(code_table[sym].code) & ((64'd1 << code_len) - 64'd1));
                    total = int'(held_count) + code_len;
                    while (total >= BYTE_BITS) begin
                        total = total - BYTE_BITS;
                        w.out_byte   = acc[total +: BYTE_BITS];
                        w.valid_bits = VB_W'(BYTE_BITS);
                        w.last       = (total < BYTE_BITS);
                        byte_queue.push_back(w);
                    end
                    held_count = 3'(total);
                    held_bits  = 7'(acc & ((64'd1 << total) - 64'd1));
                end
            end
            OP_FLUSH: begin
                if (held_count != 0) begin
                    w.out_byte   = 8'(16'(held_bits) << (BYTE_BITS - int'(held_count)));
                    w.valid_bits = VB_W'(held_count);
                    w.last       = 1'b1;
                    byte_queue.push_back(w);
                    held_bits  = '0;
                    held_count = '0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_byte();
        packed_byte_t w;
        if (byte_queue.size() == 0) begin
            fail_count++;
            $error("unexpected output word: out_byte %02h valid_bits %0d last %0d",
                   m_out_byte, m_valid_bits, m_last);
        end else begin
            w = byte_queue.pop_front();
            if (m_out_byte !== w.out_byte) begin
                fail_count++;
                $error("out_byte: expected %02h, actual %02h", w.out_byte, m_out_byte);
            end
            if (m_valid_bits !== w.valid_bits) begin
                fail_count++;
                $error("valid_bits: expected %0d, actual %0d", w.valid_bits, m_valid_bits);
            end
            if (m_last !== w.last) begin
                fail_count++;
                $error("last: expected %0d, actual %0d", w.last, m_last);
            end
        end
    endtask

    initial begin
        fail_count    = 0;
        words_waiting = 0;
        words_in      = 0;
        words_out     = 0;
        held_bits     = '0;
        held_count    = '0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            held_bits  = '0;
            held_count = '0;
            byte_queue.delete();
        end else begin
            if (m_valid && m_ready) begin
                words_out++;
                check_byte();
            end
            if (s_valid && s_ready) begin
                words_in++;
                pack_word(s_opcode, s_symbol, s_code_bits, s_code_length);
            end
        end
        words_waiting = byte_queue.size();
    end

endmodule

### tb/tb_prefix_code_bit_packer_top.sv
`timescale 1ns / 1ps

module tb_prefix_code_bit_packer_top;
    import pcbp_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         HOLD_CYCLES = 300;
    localparam int         TAIL_CYCLES = 20;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_opcode;
    logic [SYM_W-1:0]     s_symbol;
    logic [CODE_W-1:0]    s_code_bits;
    logic [LEN_W-1:0]     s_code_length;
    logic                 m_valid;
    logic                 m_ready;
    logic [BYTE_BITS-1:0] m_out_byte;
    logic [VB_W-1:0]      m_valid_bits;
    logic                 m_last;

    int fail_count;
    int words_waiting;
    int words_in;
    int words_out;
    int cycle_count;
    int src_idle_pct;
    int snk_stall_pct;
    bit hold_req;

    bit               sym_loaded [2**SYM_W];
    logic [SYM_W-1:0] loaded_syms [$];

    prefix_code_bit_packer_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_symbol      (s_symbol),
        .s_code_bits   (s_code_bits),
        .s_code_length (s_code_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_valid_bits  (m_valid_bits),
        .m_last        (m_last)
    );

    prefix_code_bit_packer_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_opcode      (s_opcode),
        .s_symbol      (s_symbol),
        .s_code_bits   (s_code_bits),
        .s_code_length (s_code_length),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_valid_bits  (m_valid_bits),
        .m_last        (m_last),
        .fail_count    (fail_count),
        .words_waiting (words_waiting),
        .words_in      (words_in),
        .words_out     (words_out)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILED: results differ");
        $finish;
    end

    // receiver: random stalls, plus one long hold on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end
            m_ready = ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input logic [1:0] op, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_opcode      = op;
        s_symbol      = sym;
        s_code_bits   = bits;
        s_code_length = len;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic load_entry(input logic [SYM_W-1:0] sym, input logic [CODE_W-1:0] bits,
                              input logic [LEN_W-1:0] len);
        send_word(OP_LOAD, sym, bits, len);
        if (!sym_loaded[sym]) begin
            sym_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endtask

    // unused fields carry random content
    task automatic encode_symbol(input logic [SYM_W-1:0] sym);
        send_word(OP_ENCODE, sym, $urandom, LEN_W'($urandom));
    endtask

    task automatic flush_bits();
        send_word(OP_FLUSH, SYM_W'($urandom), $urandom, LEN_W'($urandom));
    endtask

    task automatic random_word();
        int               r;
        int               k;
        logic [LEN_W-1:0] len;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            k = $urandom_range(0, 99);
            if (k < 5)       len = '0;
            else if (k < 10) len = LEN_W'($urandom_range(33, 63));
            else if (k < 25) len = LEN_W'($urandom_range(13, 32));
            else             len = LEN_W'($urandom_range(1, 12));
            load_entry(SYM_W'($urandom), $urandom, len);
        end else if (r < 85) begin
            encode_symbol(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
        end else if (r < 97) begin
            flush_bits();
        end else begin
            send_word(OP_RESERVED, SYM_W'($urandom), $urandom, LEN_W'($urandom));
        end
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct, input int n);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        repeat (n) random_word();
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_opcode      = OP_LOAD;
        s_symbol      = '0;
        s_code_bits   = '0;
        s_code_length = '0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_req      = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: extremes, saturation, empty cases, partial flushes
        load_entry(8'd0, 32'hFFFF_FFFF, 6'd32);
        load_entry(8'd255, 32'h0000_0000, 6'd0);
        load_entry(8'd1, 32'h0000_0005, 6'd3);
        load_entry(8'd2, 32'hAAAA_AAAA, 6'd63);
        load_entry(8'd3, 32'h0000_0001, 6'd1);
        encode_symbol(8'd255);
        flush_bits();
        send_word(OP_RESERVED, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
        encode_symbol(8'd1);
        flush_bits();
        encode_symbol(8'd0);
        encode_symbol(8'd1);
        encode_symbol(8'd2);
        encode_symbol(8'd1);
        encode_symbol(8'd3);
        flush_bits();
        encode_symbol(8'd3);
        flush_bits();

        run_phase(0, 0, 15);
        run_phase(69, 0, 15);
        run_phase(0, 69, 15);
        run_phase(13, 13, 15);

        // long receiver hold while long codes keep coming
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        load_entry(8'd10, $urandom, 6'd32);
        load_entry(8'd11, $urandom, 6'd31);
        hold_req = 1'b1;
        for (int i = 0; i < 20; i++) encode_symbol(i[0] ? 8'd11 : 8'd10);
        flush_bits();

        s_valid = 1'b0;
        snk_stall_pct = 13;
        while (words_waiting != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("run covered %0d input words and %0d output words checked", words_in,
                 words_out);
        $display("loads, encodes, flushes, reserved opcodes, four idle mixes, one long hold");
        if (fail_count == 0 && words_waiting == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
